// ===== design/sbi_pkg.sv =====
package sbi_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned DistW  = 33;
    localparam int unsigned FracW  = 32;
    localparam int unsigned NumFace = 6;
    localparam int unsigned InW    = 12 * CoordW;
    localparam int unsigned OutW   = 104;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic [FracW-1:0]         t_frac;

    typedef struct packed {
        t_coord bmin_x, bmin_y, bmin_z;
        t_coord bmax_x, bmax_y, bmax_z;
        t_coord s_x, s_y, s_z;
        t_coord e_x, e_y, e_z;
    } t_item;

    // Plane of one face: x-min, y-min, z-min, x-max, y-max, z-max.
    function automatic t_coord face_plane(input t_item it, input int unsigned f);
        t_coord p;
        case (f)
            0: p = it.bmin_x;
            1: p = it.bmin_y;
            2: p = it.bmin_z;
            3: p = it.bmax_x;
            4: p = it.bmax_y;
            default: p = it.bmax_z;
        endcase
        return p;
    endfunction

    function automatic t_coord axis_val(input t_coord x, input t_coord y, input t_coord z,
                                        input int unsigned a);
        t_coord v;
        case (a)
            0: v = x;
            1: v = y;
            default: v = z;
        endcase
        return v;
    endfunction

endpackage

// ===== design/segment_box_intersection.sv =====
// Segment versus axis-aligned box test, signed Q16.16 coordinates. One item in and one
// result out per cycle when the output is not stalled. Stages in order:
// two setup stages compute the six plane distances, 32 stages run a restoring divider
// per face (one quotient bit per stage), a 32x33 multiply per face and axis sits in a
// multiply stage, then add/inside tests and the face priority select follow. A stall
// on the output freezes the whole pipeline; the skid-free global enable keeps order.
module segment_box_intersection
    import sbi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
    input  logic [InW-1:0]  s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // hit (bit 0), hit_x [32:1], hit_y [64:33], hit_z [96:65], zero fill
    output logic [OutW-1:0] m_axis_tdata
);

    localparam int unsigned DivSt = FracW;
    localparam int unsigned NumSt = DivSt + 6;

    logic w_en;
    assign w_en          = m_axis_tready | ~m_axis_tvalid;
    assign s_axis_tready = w_en & i_rst_n;

    logic [NumSt-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NumSt-2:0], s_axis_tvalid};
        end
    end

    // ---- stage 0: register input
    t_item r_it0;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it0.bmin_x <= s_axis_tdata[0*CoordW +: CoordW];
            r_it0.bmin_y <= s_axis_tdata[1*CoordW +: CoordW];
            r_it0.bmin_z <= s_axis_tdata[2*CoordW +: CoordW];
            r_it0.bmax_x <= s_axis_tdata[3*CoordW +: CoordW];
            r_it0.bmax_y <= s_axis_tdata[4*CoordW +: CoordW];
            r_it0.bmax_z <= s_axis_tdata[5*CoordW +: CoordW];
            r_it0.s_x    <= s_axis_tdata[6*CoordW +: CoordW];
            r_it0.s_y    <= s_axis_tdata[7*CoordW +: CoordW];
            r_it0.s_z    <= s_axis_tdata[8*CoordW +: CoordW];
            r_it0.e_x    <= s_axis_tdata[9*CoordW +: CoordW];
            r_it0.e_y    <= s_axis_tdata[10*CoordW +: CoordW];
            r_it0.e_z    <= s_axis_tdata[11*CoordW +: CoordW];
        end
    end

    // ---- stage 1: distances, crossing flags, reject and inside tests
    logic [DistW-1:0] n_m1 [NumFace];
    logic [DistW-1:0] n_m2 [NumFace];
    logic [NumFace-1:0] n_cross;
    logic n_rej, n_in;
    always_comb begin
        logic signed [DistW-1:0] d1, d2;
        t_coord p, sa, ea, lo, hi;
        n_rej = 1'b0;
        n_in  = 1'b1;
        for (int a = 0; a < 3; a++) begin
            sa = axis_val(r_it0.s_x, r_it0.s_y, r_it0.s_z, a);
            ea = axis_val(r_it0.e_x, r_it0.e_y, r_it0.e_z, a);
            lo = face_plane(r_it0, a);
            hi = face_plane(r_it0, a + 3);
            if ((sa < lo && ea < lo) || (sa > hi && ea > hi)) n_rej = 1'b1;
            if (!(sa > lo && sa < hi)) n_in = 1'b0;
        end
        for (int f = 0; f < NumFace; f++) begin
            p  = face_plane(r_it0, f);
            sa = axis_val(r_it0.s_x, r_it0.s_y, r_it0.s_z, f % 3);
            ea = axis_val(r_it0.e_x, r_it0.e_y, r_it0.e_z, f % 3);
            d1 = DistW'(sa) - DistW'(p);
            d2 = DistW'(ea) - DistW'(p);
            n_cross[f] = (d1 != 0) && (d2 != 0) && (d1[DistW-1] != d2[DistW-1]);
            n_m1[f] = d1[DistW-1] ? DistW'(-d1) : DistW'(d1);
            n_m2[f] = d2[DistW-1] ? DistW'(-d2) : DistW'(d2);
        end
    end

    t_item r_it [DivSt+2];
    logic [NumFace-1:0] r_cross [DivSt+2];
    logic r_rej [DivSt+2];
    logic r_in  [DivSt+2];
    logic [DistW:0]   r_rem [DivSt+1][NumFace];
    logic [DistW:0]   r_den [DivSt+1][NumFace];
    t_frac            r_q   [DivSt+1][NumFace];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it[0]    <= r_it0;
            r_cross[0] <= n_cross;
            r_rej[0]   <= n_rej;
            r_in[0]    <= n_in;
            for (int f = 0; f < NumFace; f++) begin
                r_rem[0][f] <= {1'b0, n_m1[f]};
                r_den[0][f] <= {1'b0, n_m1[f]} + {1'b0, n_m2[f]};
                r_q[0][f]   <= '0;
            end
        end
    end

    // ---- divider stages: one quotient bit per stage per face
    for (genvar g = 0; g < DivSt; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [DistW+1:0] sh;
            if (w_en) begin
                r_it[g+1]    <= r_it[g];
                r_cross[g+1] <= r_cross[g];
                r_rej[g+1]   <= r_rej[g];
                r_in[g+1]    <= r_in[g];
                for (int f = 0; f < NumFace; f++) begin
                    sh = {r_rem[g][f], 1'b0};
                    r_den[g+1][f] <= r_den[g][f];
                    if (sh >= {1'b0, r_den[g][f]}) begin
                        r_rem[g+1][f] <= (DistW+1)'(sh - {1'b0, r_den[g][f]});
                        r_q[g+1][f]   <= {r_q[g][f][FracW-2:0], 1'b1};
                    end else begin
                        r_rem[g+1][f] <= (DistW+1)'(sh);
                        r_q[g+1][f]   <= {r_q[g][f][FracW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---- multiply stage: |delta| * t per face and axis
    logic [DistW+FracW-1:0] r_prod [NumFace][3];
    logic [2:0]             r_neg  [NumFace];
    always_ff @(posedge i_clk) begin
        logic signed [DistW-1:0] dl;
        logic [DistW-1:0] mg;
        if (w_en) begin
            r_it[DivSt+1]    <= r_it[DivSt];
            r_cross[DivSt+1] <= r_cross[DivSt];
            r_rej[DivSt+1]   <= r_rej[DivSt];
            r_in[DivSt+1]    <= r_in[DivSt];
            for (int f = 0; f < NumFace; f++) begin
                for (int k = 0; k < 3; k++) begin
                    dl = DistW'(axis_val(r_it[DivSt].e_x, r_it[DivSt].e_y, r_it[DivSt].e_z, k))
                       - DistW'(axis_val(r_it[DivSt].s_x, r_it[DivSt].s_y, r_it[DivSt].s_z, k));
                    mg = dl[DistW-1] ? DistW'(-dl) : DistW'(dl);
                    r_neg[f][k]  <= dl[DistW-1];
                    r_prod[f][k] <= (DistW+FracW)'(mg) * (DistW+FracW)'(r_q[DivSt][f]);
                end
            end
        end
    end

    // ---- step stage: scaled step added to start
    t_coord r_c [NumFace][3];
    t_item  r_itc;
    logic [NumFace-1:0] r_crossc;
    logic r_rejc, r_inc;
    always_ff @(posedge i_clk) begin
        logic [DistW-1:0] up;
        logic signed [DistW:0] st;
        if (w_en) begin
            r_itc    <= r_it[DivSt+1];
            r_crossc <= r_cross[DivSt+1];
            r_rejc   <= r_rej[DivSt+1];
            r_inc    <= r_in[DivSt+1];
            for (int f = 0; f < NumFace; f++) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_neg[f][k]) begin
                        up = DistW'((r_prod[f][k] + (DistW+FracW)'(32'hFFFF_FFFF)) >> FracW);
                        st = -$signed({1'b0, up});
                    end else begin
                        st = $signed({1'b0, DistW'(r_prod[f][k] >> FracW)});
                    end
                    r_c[f][k] <= CoordW'((DistW+1)'(axis_val(r_it[DivSt+1].s_x,
                                 r_it[DivSt+1].s_y, r_it[DivSt+1].s_z, k)) + st);
                end
            end
        end
    end

    // ---- inside-face tests
    logic [NumFace-1:0] r_ok;
    t_coord r_cs [NumFace][3];
    t_item  r_itd;
    logic r_rejd, r_ind;
    always_ff @(posedge i_clk) begin
        logic ok;
        t_coord lo, hi;
        if (w_en) begin
            r_itd  <= r_itc;
            r_rejd <= r_rejc;
            r_ind  <= r_inc;
            r_cs   <= r_c;
            for (int f = 0; f < NumFace; f++) begin
                ok = r_crossc[f];
                for (int k = 0; k < 3; k++) begin
                    lo = face_plane(r_itc, k);
                    hi = face_plane(r_itc, k + 3);
                    if (k != (f % 3) && !(r_c[f][k] > lo && r_c[f][k] < hi)) ok = 1'b0;
                end
                r_ok[f] <= ok;
            end
        end
    end

    // ---- priority select and output register
    logic   r_hit;
    t_coord r_hx, r_hy, r_hz;
    always_ff @(posedge i_clk) begin
        logic h;
        t_coord x, y, z;
        if (w_en) begin
            h = 1'b0; x = '0; y = '0; z = '0;
            if (!r_rejd) begin
                if (r_ind) begin
                    h = 1'b1; x = r_itd.s_x; y = r_itd.s_y; z = r_itd.s_z;
                end else begin
                    for (int f = NumFace - 1; f >= 0; f--) begin
                        if (r_ok[f]) begin
                            h = 1'b1; x = r_cs[f][0]; y = r_cs[f][1]; z = r_cs[f][2];
                        end
                    end
                end
            end
            r_hit <= h;
            r_hx  <= x;
            r_hy  <= y;
            r_hz  <= z;
        end
    end

    assign m_axis_tvalid = r_vld[NumSt-1];
    assign m_axis_tdata  = {7'd0, r_hz, r_hy, r_hx, r_hit};

endmodule

// ===== dv/sbi_checker.sv =====
`timescale 1ns / 100ps

module sbi_checker
    import sbi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    input  logic            s_axis_tready,
    input  logic [InW-1:0]  s_axis_tdata,
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  logic [OutW-1:0] m_axis_tdata,
    output int              o_fail_count,
    output int              o_pending
);

    logic [OutW-1:0] hits_expected[$];

    // field k of the item, first field in the lowest bits
    function automatic logic signed [63:0] coord_at(input t_item it, input int unsigned k);
        t_coord c;
        c = it[32*k +: 32];
        return 64'(c);
    endfunction

    // floor(num * 2^32 / den), num < den
    function automatic logic [31:0] crossing_frac(input logic [63:0] num,
                                                  input logic [63:0] den);
        logic [127:0] q;
        q = {num, 32'd0} / {64'd0, den};
        return q[31:0];
    endfunction

    function automatic logic signed [63:0] lerp_coord(input logic signed [63:0] p1,
                                                      input logic signed [63:0] p2,
                                                      input logic [31:0] t);
        logic signed [63:0] delta;
        logic signed [127:0] prod;
        delta = p2 - p1;
        prod = 128'(delta) * $signed({96'd0, t});
        return p1 + 64'(prod >>> 32);
    endfunction

    function automatic bit between(input logic signed [63:0] v, input logic signed [63:0] lo,
                                   input logic signed [63:0] hi);
        return v > lo && v < hi;
    endfunction

    function automatic logic [OutW-1:0] predict_hit(input t_item it);
        logic signed [63:0] lo[3], hi[3], s[3], e[3], h[3], c[3];
        logic signed [63:0] plane, d1, d2;
        logic [63:0] m1, m2;
        logic [31:0] t;
        bit hit, rejected, ok;
        int ax;
        logic [OutW-1:0] r;
        hit = 0;
        rejected = 0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = coord_at(it, a);
            hi[a] = coord_at(it, 3 + a);
            s[a] = coord_at(it, 6 + a);
            e[a] = coord_at(it, 9 + a);
            h[a] = 0;
            if ((s[a] < lo[a] && e[a] < lo[a]) || (s[a] > hi[a] && e[a] > hi[a]))
                rejected = 1;
        end
        if (!rejected) begin
            if (between(s[0], lo[0], hi[0]) && between(s[1], lo[1], hi[1]) &&
                between(s[2], lo[2], hi[2])) begin
                hit = 1;
                for (int a = 0; a < 3; a++) h[a] = s[a];
            end
            for (int f = 0; f < 6 && !hit; f++) begin
                ax = f % 3;
                plane = f < 3 ? lo[ax] : hi[ax];
                d1 = s[ax] - plane;
                d2 = e[ax] - plane;
                if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)) begin
                    m1 = d1 < 0 ? -d1 : d1;
                    m2 = d2 < 0 ? -d2 : d2;
                    t = crossing_frac(m1, m1 + m2);
                    ok = 1;
                    for (int k = 0; k < 3; k++) begin
                        c[k] = lerp_coord(s[k], e[k], t);
                        if (k != ax && !between(c[k], lo[k], hi[k])) ok = 0;
                    end
                    if (ok) begin
                        hit = 1;
                        for (int k = 0; k < 3; k++) h[k] = c[k];
                    end
                end
            end
        end
        if (!hit) for (int a = 0; a < 3; a++) h[a] = 0;
        r = '0;
        r[0] = hit;
        r[32:1] = h[0][31:0];
        r[64:33] = h[1][31:0];
        r[96:65] = h[2][31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic [OutW-1:0] want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                hits_expected.push_back(predict_hit(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (hits_expected.size() == 0) begin
                    $display("%0t: unexpected item expected none actual %h", $time,
                             m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hits_expected.pop_front();
                    if (want[0] !== m_axis_tdata[0] || want[32:1] !== m_axis_tdata[32:1] ||
                        want[64:33] !== m_axis_tdata[64:33] ||
                        want[96:65] !== m_axis_tdata[96:65] ||
                        m_axis_tdata[OutW-1:97] !== '0) begin
                        $display({"%0t: mismatch expected hit=%b x=%h y=%h z=%h",
                                  " actual hit=%b x=%h y=%h z=%h"},
                                 $time, want[0], want[32:1], want[64:33], want[96:65],
                                 m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[64:33],
                                 m_axis_tdata[96:65]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= hits_expected.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import sbi_pkg::*;
();

    localparam int Latency = 38;
    localparam int CycleLimit = 400000;

    logic            i_clk;
    logic            i_rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [InW-1:0]  s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [OutW-1:0] m_axis_tdata;
    int              fail_count;
    int              pending;
    int              cycles;
    int              idle_pct;
    int              stall_pct;

    segment_box_intersection uut (.*);

    sbi_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= !i_rst_n || $urandom_range(99) >= stall_pct;

    function automatic t_coord rand_coord(input int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(40)) - 20) <<< 16;
            default: return t_coord'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // a box with a segment; mode picks the coordinate scale, low/high sorted mostly
    function automatic t_item make_item(input int mode);
        t_item it;
        t_coord a, b;
        for (int k = 0; k < 3; k++) begin
            a = rand_coord(mode);
            b = rand_coord(mode);
            if ($urandom_range(9) != 0 && a > b) begin
                it[32*k +: 32] = b;
                it[32*(k+3) +: 32] = a;
            end else begin
                it[32*k +: 32] = a;
                it[32*(k+3) +: 32] = b;
            end
            it[32*(k+6) +: 32] = rand_coord(mode);
            it[32*(k+9) +: 32] = rand_coord(mode);
        end
        return it;
    endfunction

    task automatic send_item(input t_item it);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= it;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // first field in the lowest bits
    function automatic t_item pack_item(input t_coord lx, ly, lz, hx, hy, hz,
                                        sx, sy, sz, ex, ey, ez);
        return {ez, ey, ex, sz, sy, sx, hz, hy, hx, lz, ly, lx};
    endfunction

    initial begin
        localparam t_coord One = 32'sh10000;
        localparam t_coord Lo = 32'sh80000000;
        localparam t_coord Hi = 32'sh7fffffff;
        t_item it;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // start inside, each face crossing, rejections, on-plane ends, inverted box
        send_item(pack_item(-One, -One, -One, One, One, One, 0, 0, 0, 5*One, 0, 0));
        send_item(pack_item(-One, -One, -One, One, One, One, -3*One, 0, 0, 3*One, 0, 0));
        send_item(pack_item(-One, -One, -One, One, One, One, 0, -3*One, 0, 1, 3*One, 3));
        send_item(pack_item(-One, -One, -One, One, One, One, 0, 0, -3*One, 7, 5, 3*One));
        send_item(pack_item(-One, -One, -One, One, One, One, 3*One, 0, 0, -3*One, 1, 2));
        send_item(pack_item(-One, -One, -One, One, One, One, 0, 3*One, 0, 3, -3*One, 0));
        send_item(pack_item(-One, -One, -One, One, One, One, 5, 9, 3*One, -7, 0, -3*One));
        send_item(pack_item(-One, -One, -One, One, One, One, -3*One, 0, 0, -2*One, 0, 0));
        send_item(pack_item(-One, -One, -One, One, One, One, 0, 3*One, 0, 0, 2*One, 0));
        send_item(pack_item(-One, -One, -One, One, One, One, -One, 0, 0, One, 0, 0));
        send_item(pack_item(-One, -One, -One, One, One, One, -3*One, One, 0, 3*One, One, 0));
        send_item(pack_item(One, One, One, -One, -One, -One, 0, 0, 0, 3*One, 0, 0));
        send_item(pack_item(Lo, Lo, Lo, Hi, Hi, Hi, 0, 0, 0, Hi, Hi, Hi));
        send_item(pack_item(Lo, Lo, Lo, Hi, Hi, Hi, Lo, Lo, Lo, Hi, Hi, Hi));
        send_item(pack_item(Lo+1, Lo+1, Lo+1, Hi-1, Hi-1, Hi-1, Lo, 0, 0, Hi, 1, -1));
        send_item(pack_item(Lo+1, Lo+1, Lo+1, Hi-1, Hi-1, Hi-1, Hi, -5, 3, Lo, 7, -9));
        send_item(pack_item(-1, -1, -1, 1, 1, 1, -2, 0, 0, 2, 0, 0));
        send_item(pack_item('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_item(pack_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin idle_pct = 51; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 51; end
                3: begin idle_pct = 6; stall_pct = 6; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 130; n++) begin
                it = make_item($urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2));
                send_item(it);
            end
        end
        s_axis_tvalid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sbi_pkg.sv
design/segment_box_intersection.sv
dv/sbi_checker.sv
dv/testbench.sv
